@@ sv/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, command and status types for the transition stats block.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int NUM_STATES    = 4;
    localparam int ITERATIONS    = 64;
    localparam int COUNT_WIDTH   = 32;
    localparam int FRACTION_BITS = 24;

    localparam int CELLS   = NUM_STATES * NUM_STATES;
    localparam int SW      = $clog2(NUM_STATES);
    localparam int CW      = $clog2(CELLS);
    localparam int ITW     = $clog2(ITERATIONS + 1);
    localparam int PW      = FRACTION_BITS + 1;
    localparam int RTW     = COUNT_WIDTH + SW;
    localparam int QW      = $clog2(FRACTION_BITS + 1);
    localparam int SUMW    = PW + SW;

    localparam logic [1:0] OP_ARM     = 2'd0;
    localparam logic [1:0] OP_OBSERVE = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;

    // Datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_CLEAR     = 4'd1;
    localparam logic [3:0] CMD_OBSERVE   = 4'd2;
    localparam logic [3:0] CMD_ROW_LOAD  = 4'd3;  // accumulate row total
    localparam logic [3:0] CMD_DIV_START = 4'd4;  // start divider
    localparam logic [3:0] CMD_DIV_STEP  = 4'd5;
    localparam logic [3:0] CMD_STORE_P   = 4'd6;
    localparam logic [3:0] CMD_INIT_VEC  = 4'd7;
    localparam logic [3:0] CMD_MAC       = 4'd8;  // one product into nx
    localparam logic [3:0] CMD_STORE_V   = 4'd9;
    localparam logic [3:0] CMD_EMIT      = 4'd10;
    localparam logic [3:0] CMD_CLR_NX    = 4'd11;
    localparam logic [3:0] CMD_MUL       = 4'd12;  // register product

    typedef struct packed {
        logic [3:0]      cmd;
        logic [CW-1:0]   cidx;    // cell index i*N+j
        logic [SW-1:0]   idx;     // vector index
        logic            div_nx;  // divider source: 1 nx/norm, 0 count/row
        logic            kind;
        logic            last;
        logic            stat_ok;
    } mts_cmd_t;

    typedef struct packed {
        logic any;
        logic norm_zero;
    } mts_status_t;

endpackage

@@ sv/mts_datapath.sv @@
// ----------------------------------------------------------------------------
// mts_datapath
// Count table, row totals, shared restoring divider and multiply-accumulate.
// ----------------------------------------------------------------------------
module mts_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mts_pkg::mts_cmd_t      cmd,
    input  logic [2:0]             prev_state,
    input  logic [2:0]             next_state,
    output mts_pkg::mts_status_t   status,
    output logic                   strobe,
    output logic                   entry_kind,
    output logic [1:0]             row,
    output logic [1:0]             column,
    output logic [31:0]            count,
    output logic [16:0]            fraction,
    output logic                   valid_res,
    output logic                   last
);
    import mts_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_reg [CELLS];
    logic [PW-1:0]          prob_reg [CELLS];
    logic [PW-1:0]          vec_reg [NUM_STATES];
    logic [SUMW-1:0]        nx_reg [NUM_STATES];
    logic [SUMW-1:0]        norm_reg;
    logic [RTW-1:0]         rt_reg;
    logic [RTW:0]           rem_reg;
    logic [RTW-1:0]         den_reg;
    logic [PW-1:0]          q_reg;
    logic                   sat_reg;
    logic [2*PW-1:0]        prod_reg;

    logic                   strobe_reg;
    logic                   kind_reg;
    logic [1:0]             row_reg;
    logic [1:0]             col_reg;
    logic [31:0]            count_reg;
    logic [16:0]            frac_reg;
    logic                   ok_reg;
    logic                   last_reg;

    logic                   any_w;
    logic [SW-1:0]          ci;
    logic [SW-1:0]          cj;
    logic [RTW:0]           rem_sh;
    logic [RTW-1:0]         num_w;
    logic [RTW-1:0]         den_w;
    logic [PW-1:0]          q_out;
    logic [PW-1:0]          out_p;

    assign ci = cmd.cidx[CW-1:SW];
    assign cj = cmd.cidx[SW-1:0];

    always_comb
    begin
        any_w = 1'b0;
        for (int k = 0; k < CELLS; k++)
            any_w = any_w | (cnt_reg[k] != '0);
    end

    assign status.any       = any_w;
    assign status.norm_zero = (norm_reg == '0);

    always_comb
    begin
        if (cmd.div_nx)
        begin
            num_w = RTW'(nx_reg[cmd.idx]);
            den_w = RTW'(norm_reg);
        end
        else
        begin
            num_w = RTW'(cnt_reg[cmd.cidx]);
            den_w = rt_reg;
        end
    end

    assign rem_sh = {rem_reg[RTW-1:0], 1'b0};
    assign q_out  = sat_reg ? PW'(1 << FRACTION_BITS) : q_reg;
    assign out_p  = cmd.kind ? vec_reg[cmd.idx] : prob_reg[cmd.cidx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELLS; k++)
                cnt_reg[k] <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.cmd == CMD_EMIT);
            if (cmd.cmd == CMD_CLEAR)
            begin
                for (int k = 0; k < CELLS; k++)
                    cnt_reg[k] <= '0;
            end
            else if (cmd.cmd == CMD_OBSERVE && !prev_state[2] && !next_state[2])
            begin
                if (cnt_reg[{prev_state[1:0], next_state[1:0]}] != '1)
                    cnt_reg[{prev_state[1:0], next_state[1:0]}] <=
                        cnt_reg[{prev_state[1:0], next_state[1:0]}] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.cmd)
            CMD_ROW_LOAD:
            begin
                // row total over the four cells of row ci
                rt_reg <= RTW'(cnt_reg[{ci, 2'd0}]) + RTW'(cnt_reg[{ci, 2'd1}])
                        + RTW'(cnt_reg[{ci, 2'd2}]) + RTW'(cnt_reg[{ci, 2'd3}]);
            end
            CMD_DIV_START:
            begin
                rem_reg <= (den_w == '0) ? '0 : {1'b0, num_w};
                den_reg <= den_w;
                q_reg   <= '0;
                sat_reg <= (den_w == '0) ? 1'b0 : (num_w >= den_w);
            end
            CMD_DIV_STEP:
            begin
                if (rem_sh >= {1'b0, den_reg} && den_reg != '0)
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    q_reg   <= {q_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[PW-2:0], 1'b0};
                end
            end
            CMD_STORE_P:
                prob_reg[cmd.cidx] <= q_out;
            CMD_INIT_VEC:
            begin
                for (int k = 0; k < NUM_STATES; k++)
                    vec_reg[k] <= PW'((1 << FRACTION_BITS) / NUM_STATES);
            end
            CMD_CLR_NX:
            begin
                for (int k = 0; k < NUM_STATES; k++)
                    nx_reg[k] <= '0;
                norm_reg <= '0;
            end
            CMD_MUL:
                prod_reg <= vec_reg[ci] * prob_reg[cmd.cidx];
            CMD_MAC:
            begin
                nx_reg[cj] <= nx_reg[cj] + SUMW'(prod_reg >> FRACTION_BITS);
                norm_reg   <= norm_reg + SUMW'(prod_reg >> FRACTION_BITS);
            end
            CMD_STORE_V:
                vec_reg[cmd.idx] <= q_out;
            CMD_EMIT:
            begin
                kind_reg  <= cmd.kind;
                row_reg   <= cmd.kind ? 2'(cmd.idx) : 2'(ci);
                col_reg   <= cmd.kind ? 2'd0 : 2'(cj);
                count_reg <= cmd.kind ? 32'd0 : 32'(cnt_reg[cmd.cidx]);
                ok_reg    <= cmd.stat_ok;
                frac_reg  <= cmd.stat_ok ? 17'(out_p >> (FRACTION_BITS - 16)) : 17'd0;
                last_reg  <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign strobe     = strobe_reg;
    assign entry_kind = kind_reg;
    assign row        = row_reg;
    assign column     = col_reg;
    assign count      = count_reg;
    assign fraction   = frac_reg;
    assign valid_res  = ok_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> fraction <= 17'd65536)
        else $error("fraction above one");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !valid_res |-> fraction == 17'd0)
        else $error("invalid result with nonzero fraction");
    a_stat_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && entry_kind |-> count == 32'd0 && column == 2'd0)
        else $error("stationary result with count");
`endif

endmodule

@@ sv/mts_ctrl.sv @@
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for arm, observe and the report walk with power iteration.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             operation,
    input  mts_pkg::mts_status_t   status,
    output logic                   busy,
    output mts_pkg::mts_cmd_t      cmd
);
    import mts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RT     = 4'd1;
    localparam logic [3:0] S_PSTART = 4'd2;
    localparam logic [3:0] S_PDIV   = 4'd3;
    localparam logic [3:0] S_PSTORE = 4'd4;
    localparam logic [3:0] S_INIT   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_MAC    = 4'd7;
    localparam logic [3:0] S_CHECK  = 4'd8;
    localparam logic [3:0] S_VSTART = 4'd9;
    localparam logic [3:0] S_VDIV   = 4'd10;
    localparam logic [3:0] S_VSTORE = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    logic [3:0]     state_reg, state_next;
    logic           armed_reg, armed_next;
    logic [CW-1:0]  cell_reg, cell_next;
    logic [SW-1:0]  idx_reg, idx_next;
    logic [QW-1:0]  step_reg, step_next;
    logic [ITW-1:0] iter_reg, iter_next;
    logic           any_reg, any_next;
    logic           sok_reg, sok_next;
    logic           ekind_reg, ekind_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        cell_next  = cell_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        iter_next  = iter_reg;
        any_next   = any_reg;
        sok_next   = sok_reg;
        ekind_next = ekind_reg;
        cmd        = '0;
        cmd.cmd    = CMD_NONE;
        cmd.cidx   = cell_reg;
        cmd.idx    = idx_reg;
        cmd.kind   = ekind_reg;
        cmd.div_nx = (state_reg == S_VSTART) || (state_reg == S_VDIV)
                     || (state_reg == S_VSTORE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ARM:
                        begin
                            if (!armed_reg)
                                cmd.cmd = CMD_CLEAR;
                            armed_next = 1'b1;
                        end
                        OP_OBSERVE:
                        begin
                            if (armed_reg)
                                cmd.cmd = CMD_OBSERVE;
                        end
                        OP_REPORT:
                        begin
                            any_next   = status.any;
                            cell_next  = '0;
                            state_next = S_RT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RT:
            begin
                cmd.cmd    = CMD_ROW_LOAD;
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                cmd.cmd    = CMD_DIV_START;
                step_next  = '0;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.cmd   = CMD_DIV_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == QW'(FRACTION_BITS - 1))
                    state_next = S_PSTORE;
            end
            S_PSTORE:
            begin
                cmd.cmd   = CMD_STORE_P;
                cell_next = cell_reg + 1'b1;
                if (cell_reg == CW'(CELLS - 1))
                    state_next = S_INIT;
                else if (cell_reg[SW-1:0] == SW'(NUM_STATES - 1))
                    state_next = S_RT;
                else
                    state_next = S_PSTART;
            end
            S_INIT:
            begin
                cmd.cmd    = CMD_INIT_VEC;
                sok_next   = any_reg;
                iter_next  = '0;
                cell_next  = '0;
                if (any_reg)
                    state_next = S_MUL;
                else
                begin
                    ekind_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.cmd = (cell_reg == '0) ? CMD_CLR_NX : CMD_NONE;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // product registered here, accumulated in S_CHECK
                cmd.cmd    = CMD_MUL;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.cmd   = CMD_MAC;
                cell_next = cell_reg + 1'b1;
                if (cell_reg == CW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_VSTART;
                end
                else
                    state_next = S_MUL;
            end
            S_VSTART:
            begin
                if (status.norm_zero)
                begin
                    sok_next   = 1'b0;
                    cell_next  = '0;
                    ekind_next = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.cmd    = CMD_DIV_START;
                    step_next  = '0;
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                cmd.cmd   = CMD_DIV_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == QW'(FRACTION_BITS - 1))
                    state_next = S_VSTORE;
            end
            S_VSTORE:
            begin
                cmd.cmd  = CMD_STORE_V;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SW'(NUM_STATES - 1))
                begin
                    iter_next = iter_reg + 1'b1;
                    cell_next = '0;
                    if (iter_reg == ITW'(ITERATIONS - 1))
                    begin
                        ekind_next = 1'b0;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_MUL;
                end
                else
                    state_next = S_VSTART;
            end
            S_EMIT:
            begin
                cmd.cmd     = CMD_EMIT;
                cmd.stat_ok = ekind_reg ? sok_reg : any_reg;
                cmd.last    = ekind_reg && (idx_reg == SW'(NUM_STATES - 1));
                if (!ekind_reg)
                begin
                    cell_next = cell_reg + 1'b1;
                    if (cell_reg == CW'(CELLS - 1))
                    begin
                        ekind_next = 1'b1;
                        idx_next   = '0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == SW'(NUM_STATES - 1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            armed_reg <= 1'b0;
            cell_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            iter_reg  <= '0;
            any_reg   <= 1'b0;
            sok_reg   <= 1'b0;
            ekind_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            cell_reg  <= cell_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            iter_reg  <= iter_next;
            any_reg   <= any_next;
            sok_reg   <= sok_next;
            ekind_reg <= ekind_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |-> cmd.cmd == CMD_NONE)
        else $error("command issued while idle");
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_REPORT |=> busy)
        else $error("report did not start");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |=> !busy)
        else $error("last without return to idle");
`endif

endmodule

@@ sv/markov_transition_stats.sv @@
// ----------------------------------------------------------------------------
// markov_transition_stats
// 4x4 saturating transition counter with row probabilities and stationary
// vector by power iteration.
// ----------------------------------------------------------------------------
// Arm and observe give no result.
// Report: a row-total step per row and a divider pass per cell for the row
// probabilities, then up to 64 rounds of multiply-accumulate over the 16 cells
// plus a divider pass per state, then 20 results on consecutive cycles; the
// shared 1-bit-per-cycle divider sets the length.
// Reset clears the count table and the armed flag; results cannot be stalled.
module markov_transition_stats (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [2:0]  prev_state,
    input  logic [2:0]  next_state,
    output logic        strobe,
    output logic        entry_kind,
    output logic [1:0]  row,
    output logic [1:0]  column,
    output logic [31:0] count,
    output logic [16:0] fraction,
    output logic        valid_res,
    output logic        last
);
    import mts_pkg::*;

    mts_cmd_t    cmd;
    mts_status_t status;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    mts_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_state (prev_state),
        .next_state (next_state),
        .status     (status),
        .strobe     (strobe),
        .entry_kind (entry_kind),
        .row        (row),
        .column     (column),
        .count      (count),
        .fraction   (fraction),
        .valid_res  (valid_res),
        .last       (last)
    );

endmodule

@@ tb/sv/markov_transition_stats_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_stats_checker
// Watches the command and result channels of the transition stats block,
// tracks its own count table and armed flag, works out the cell and
// stationary results of every report and compares them field by field.
// ----------------------------------------------------------------------------
module markov_transition_stats_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [2:0]  prev_state,
    input  logic [2:0]  next_state,
    input  logic        strobe,
    input  logic        entry_kind,
    input  logic [1:0]  row,
    input  logic [1:0]  column,
    input  logic [31:0] count,
    input  logic [16:0] fraction,
    input  logic        valid_res,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);
    import mts_pkg::*;

    localparam longint unsigned PROB_ONE  = 64'd1 << FRACTION_BITS;
    localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic            KIND_CELL = 1'b0;
    localparam logic            KIND_STAT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [31:0] hits;
        logic [16:0] prob;
        logic        ok;
        logic        tail;
    } stat_entry_t;

    longint unsigned transition_table [CELLS];
    logic            is_armed;
    stat_entry_t     expected_entries [$];

    assign outstanding = expected_entries.size();

    // floor(num * 2^FRACTION_BITS / den), saturating at 1.0
    function automatic longint unsigned q_ratio(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = num;
        if (den == 0)
            return 0;
        if (num >= den)
            return PROB_ONE;
        for (int b = 0; b < FRACTION_BITS; b++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        return quo;
    endfunction

    function automatic stat_entry_t make_entry(logic kind, int src, int dst,
                                               longint unsigned hits,
                                               longint unsigned prob, logic ok,
                                               logic tail);
        stat_entry_t e;
        e.kind = kind;
        e.src  = src[1:0];
        e.dst  = dst[1:0];
        e.hits = hits[31:0];
        e.prob = ok ? 17'((prob >> (FRACTION_BITS - 16)) & 64'h1FFFF) : 17'd0;
        e.ok   = ok;
        e.tail = tail;
        return e;
    endfunction

    task automatic predict_report();
        longint unsigned probs [CELLS];
        longint unsigned vec [NUM_STATES];
        longint unsigned nx [NUM_STATES];
        longint unsigned total;
        longint unsigned norm;
        logic            any_hits;
        logic            stat_ok;
        any_hits = 1'b0;
        for (int c = 0; c < CELLS; c++)
            if (transition_table[c] != 0)
                any_hits = 1'b1;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            total = 0;
            for (int j = 0; j < NUM_STATES; j++)
                total += transition_table[i * NUM_STATES + j];
            for (int j = 0; j < NUM_STATES; j++)
                probs[i * NUM_STATES + j] = q_ratio(transition_table[i * NUM_STATES + j], total);
        end
        stat_ok = any_hits;
        for (int i = 0; i < NUM_STATES; i++)
            vec[i] = PROB_ONE / NUM_STATES;
        for (int it = 0; it < ITERATIONS && stat_ok; it++)
        begin
            norm = 0;
            for (int j = 0; j < NUM_STATES; j++)
            begin
                nx[j] = 0;
                for (int i = 0; i < NUM_STATES; i++)
                    nx[j] += (vec[i] * probs[i * NUM_STATES + j]) >> FRACTION_BITS;
                norm += nx[j];
            end
            if (norm == 0)
                stat_ok = 1'b0;
            else
                for (int j = 0; j < NUM_STATES; j++)
                    vec[j] = q_ratio(nx[j], norm);
        end
        for (int i = 0; i < NUM_STATES; i++)
            for (int j = 0; j < NUM_STATES; j++)
                expected_entries.push_back(make_entry(KIND_CELL, i, j,
                    transition_table[i * NUM_STATES + j], probs[i * NUM_STATES + j],
                    any_hits, 1'b0));
        for (int i = 0; i < NUM_STATES; i++)
            expected_entries.push_back(make_entry(KIND_STAT, i, 0, 0, vec[i], stat_ok,
                                                  i == NUM_STATES - 1));
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    initial
        mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        stat_entry_t want;
        int          slot;
        if (!rst_n)
        begin
            for (int c = 0; c < CELLS; c++)
                transition_table[c] = 0;
            is_armed = 1'b0;
            expected_entries.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (expected_entries.size() == 0)
                    report_mismatch("result with nothing pending, row", row, 0);
                else
                begin
                    want = expected_entries.pop_front();
                    if (entry_kind !== want.kind)
                        report_mismatch("entry_kind", entry_kind, want.kind);
                    if (row !== want.src)
                        report_mismatch("row", row, want.src);
                    if (column !== want.dst)
                        report_mismatch("column", column, want.dst);
                    if (count !== want.hits)
                        report_mismatch("count", count, want.hits);
                    if (fraction !== want.prob)
                        report_mismatch("fraction", fraction, want.prob);
                    if (valid_res !== want.ok)
                        report_mismatch("valid_res", valid_res, want.ok);
                    if (last !== want.tail)
                        report_mismatch("last", last, want.tail);
                end
            end
            if (start && !busy)
            begin
                case (operation)
                    OP_ARM:
                    begin
                        if (!is_armed)
                            for (int c = 0; c < CELLS; c++)
                                transition_table[c] = 0;
                        is_armed = 1'b1;
                    end
                    OP_OBSERVE:
                    begin
                        if (is_armed && prev_state < NUM_STATES && next_state < NUM_STATES)
                        begin
                            slot = prev_state * NUM_STATES + next_state;
                            if (transition_table[slot] < COUNT_TOP)
                                transition_table[slot]++;
                        end
                    end
                    OP_REPORT:
                        predict_report();
                    default:
                    begin
                        // unused code: drop
                    end
                endcase
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives arm, observe and report commands into the transition stats block,
// directed corner cases first and then random traffic under varying idle
// rates; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import mts_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 40000;
    localparam int         RANDOM_ITEMS = 360;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [2:0]  prev_state;
    logic [2:0]  next_state;
    logic        strobe;
    logic        entry_kind;
    logic [1:0]  row;
    logic [1:0]  column;
    logic [31:0] count;
    logic [16:0] fraction;
    logic        valid_res;
    logic        last;
    int          mismatches;
    int          outstanding;
    int          idle_pct;
    int          quiet_cycles;

    markov_transition_stats DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .prev_state (prev_state),
        .next_state (next_state),
        .strobe     (strobe),
        .entry_kind (entry_kind),
        .row        (row),
        .column     (column),
        .count      (count),
        .fraction   (fraction),
        .valid_res  (valid_res),
        .last       (last)
    );

    markov_transition_stats_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .prev_state  (prev_state),
        .next_state  (next_state),
        .strobe      (strobe),
        .entry_kind  (entry_kind),
        .row         (row),
        .column      (column),
        .count       (count),
        .fraction    (fraction),
        .valid_res   (valid_res),
        .last        (last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles in which neither a command nor a result moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Idle a random while, then hold the item until it is taken
    task automatic issue_command(logic [1:0] op, logic [2:0] src, logic [2:0] dst);
        logic was_busy;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        prev_state <= src;
        next_state <= dst;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
    endtask

    task automatic random_command();
        int pick;
        logic [2:0] src;
        logic [2:0] dst;
        pick = $urandom_range(99);
        src  = ($urandom_range(99) < 88) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
        dst  = ($urandom_range(99) < 88) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
        if (pick < 4)
            issue_command(OP_REPORT, src, dst);
        else if (pick < 8)
            issue_command(OP_ARM, src, dst);
        else if (pick < 11)
            issue_command(OP_UNUSED, src, dst);
        else
            issue_command(OP_OBSERVE, src, dst);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_ARM;
        prev_state   = 3'd0;
        next_state   = 3'd0;
        idle_pct     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unarmed
        issue_command(OP_REPORT, 3'd0, 3'd0);
        issue_command(OP_OBSERVE, 3'd0, 3'd1);
        issue_command(OP_UNUSED, 3'd7, 3'd7);
        issue_command(OP_ARM, 3'd0, 3'd0);
        // single transition: mass runs into an empty row and vanishes
        issue_command(OP_OBSERVE, 3'd0, 3'd1);
        issue_command(OP_REPORT, 3'd0, 3'd0);
        // arm again while armed must not clear
        issue_command(OP_ARM, 3'd5, 3'd2);
        issue_command(OP_OBSERVE, 3'd1, 3'd0);
        issue_command(OP_REPORT, 3'd0, 3'd0);
        issue_command(OP_OBSERVE, 3'd4, 3'd0);
        issue_command(OP_OBSERVE, 3'd0, 3'd7);
        issue_command(OP_OBSERVE, 3'd7, 3'd4);
        issue_command(OP_OBSERVE, 3'd2, 3'd2);
        issue_command(OP_OBSERVE, 3'd3, 3'd3);
        issue_command(OP_OBSERVE, 3'd3, 3'd0);
        issue_command(OP_OBSERVE, 3'd3, 3'd2);
        issue_command(OP_OBSERVE, 3'd2, 3'd3);
        issue_command(OP_OBSERVE, 3'd1, 3'd1);
        issue_command(OP_REPORT, 3'd6, 3'd5);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
                idle_pct = 82;
            else if (n == 2 * RANDOM_ITEMS / 3)
                idle_pct = 0;
            else if (n == 0)
                idle_pct = 14;
            random_command();
        end
        issue_command(OP_REPORT, 3'd0, 3'd0);
        start <= 1'b0;

        // let the last report get under way before draining
        @(posedge clk);
        while (busy || outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
